// ----- hdl/nic_pkg.sv -----
// Package with shared widths, codes and control types of the nested interval counter.
`timescale 1ns / 1ps

package nic_pkg;

    localparam int MaxRangesDefault = 1024;

    localparam int ActionW = 2;
    localparam int EndW    = 32;
    localparam int IndexW  = 10;
    localparam int StatusW = 2;

    localparam int CountLimit = 1023;

    localparam logic [ActionW-1:0] ActLoad  = 2'd0;
    localparam logic [ActionW-1:0] ActQuery = 2'd1;
    localparam logic [ActionW-1:0] ActClear = 2'd2;

    localparam logic [StatusW-1:0] StatOk       = 2'd0;
    localparam logic [StatusW-1:0] StatFull     = 2'd1;
    localparam logic [StatusW-1:0] StatBadIndex = 2'd2;

    typedef struct packed {
        logic accept;
        logic qref;
        logic scan;
        logic publish;
    } t_nic_cmd;

    typedef struct packed {
        logic need_scan;
        logic scan_done;
        logic out_free;
    } t_nic_stat;

endpackage

// ----- hdl/nic_if.sv -----
// Channel interfaces for command and result transfers.
`timescale 1ns / 1ps

interface nic_in_if;
    logic                        valid;
    logic                        ready;
    logic [nic_pkg::ActionW-1:0] action;
    logic [nic_pkg::EndW-1:0]    left_end;
    logic [nic_pkg::EndW-1:0]    right_end;
    logic [nic_pkg::IndexW-1:0]  query_index;

    modport source (output valid, output action, output left_end, output right_end,
                    output query_index, input ready);
    modport sink (input valid, input action, input left_end, input right_end,
                  input query_index, output ready);
endinterface

interface nic_out_if;
    logic                        valid;
    logic                        ready;
    logic [nic_pkg::StatusW-1:0] status;
    logic [nic_pkg::IndexW-1:0]  assigned_index;
    logic [nic_pkg::IndexW-1:0]  contains_count;
    logic [nic_pkg::IndexW-1:0]  inside_count;

    modport source (output valid, output status, output assigned_index,
                    output contains_count, output inside_count, input ready);
    modport sink (input valid, input status, input assigned_index,
                  input contains_count, input inside_count, output ready);
endinterface

// ----- hdl/nested_interval_count_unit.sv -----
// Top level of the nested interval counter: controller, datapath and channel wiring.
`timescale 1ns / 1ps

// The unit stores up to MAX_RANGES intervals and answers, for a stored index, how many
// other stored intervals it contains and how many enclose it. One command is taken at
// a time. A load, a clear or an unused action goes from its transfer into the result
// register, and from there into the output register once that is free. A query of a
// loaded index scans all stored intervals: the interval memory has one read port and
// the scan reads one entry per cycle, after the queried interval has been fetched.
// A query of an index at or above the fill count skips the scan. The output register
// frees the input side, so the next command is accepted while a result waits to be
// taken. Memory contents are not cleared after reset; only entries below the fill
// count are ever used in a result.
module nested_interval_count_unit #(
    parameter int MAX_RANGES = nic_pkg::MaxRangesDefault
) (
    input logic       i_clk,
    input logic       i_rst_n,
    nic_in_if.sink    i_in,
    nic_out_if.source o_out
);
    import nic_pkg::*;

    t_nic_cmd  cmd;
    t_nic_stat stat;
    logic      in_ready;

    assign i_in.ready = in_ready;

    nic_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    nic_datapath #(
        .MAX_RANGES (MAX_RANGES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_action      (i_in.action),
        .i_left_end    (i_in.left_end),
        .i_right_end   (i_in.right_end),
        .i_query_index (i_in.query_index),
        .o_out         (o_out)
    );

endmodule

// ----- hdl/nic_ctrl.sv -----
// Controller state machine that sequences loads, clears and query scans.
`timescale 1ns / 1ps

module nic_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  nic_pkg::t_nic_stat i_stat,
    output nic_pkg::t_nic_cmd  o_cmd
);
    import nic_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_QREF,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   accept;

    assign accept     = i_in_valid & r_in_ready;
    assign o_in_ready = r_in_ready;

    always_comb begin
        o_cmd.accept  = accept;
        o_cmd.qref    = (r_state == S_QREF);
        o_cmd.scan    = (r_state == S_SCAN);
        o_cmd.publish = (r_state == S_DONE) & i_stat.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_in_ready <= 1'b0;
                        r_state    <= i_stat.need_scan ? S_QREF : S_DONE;
                    end
                end
                S_QREF: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (i_stat.scan_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_stat.out_free) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_ready <= 1'b1;
                end
            endcase
        end
    end

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_ready |-> (r_state == S_IDLE))
        else $error("Input ready outside the idle state.");

    a_publish_in_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && i_stat.out_free |=> (r_state == S_IDLE) && r_in_ready)
        else $error("Controller did not return to idle after publishing.");

    a_scan_follows_qref: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QREF) |=> (r_state == S_SCAN))
        else $error("Reference fetch was not followed by the scan.");

endmodule

// ----- hdl/nic_datapath.sv -----
// Datapath with the interval memories, fill count, scan counters and result register.
`timescale 1ns / 1ps

module nic_datapath #(
    parameter int MAX_RANGES = nic_pkg::MaxRangesDefault
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  nic_pkg::t_nic_cmd            i_cmd,
    output nic_pkg::t_nic_stat           o_stat,
    input  logic [nic_pkg::ActionW-1:0]  i_action,
    input  logic [nic_pkg::EndW-1:0]     i_left_end,
    input  logic [nic_pkg::EndW-1:0]     i_right_end,
    input  logic [nic_pkg::IndexW-1:0]   i_query_index,
    nic_out_if.source                    o_out
);
    import nic_pkg::*;

    localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int XW = (CW > IndexW) ? CW : IndexW;

    logic [EndW-1:0] r_left_mem  [MAX_RANGES];
    logic [EndW-1:0] r_right_mem [MAX_RANGES];

    logic [CW-1:0]      r_count;
    logic [EndW-1:0]    r_rd_left;
    logic [EndW-1:0]    r_rd_right;
    logic [EndW-1:0]    r_q_left;
    logic [EndW-1:0]    r_q_right;
    logic [AW-1:0]      r_q_idx;
    logic [CW-1:0]      r_scan;
    logic               r_pend;
    logic [AW-1:0]      r_pend_idx;
    logic [CW-1:0]      r_within;
    logic [CW-1:0]      r_around;
    logic [StatusW-1:0] r_res_status;
    logic [IndexW-1:0]  r_res_assigned;

    logic               r_out_valid;
    logic [StatusW-1:0] r_out_status;
    logic [IndexW-1:0]  r_out_assigned;
    logic [IndexW-1:0]  r_out_contains;
    logic [IndexW-1:0]  r_out_inside;

    logic [XW-1:0]   q_ext;
    logic [XW-1:0]   count_ext;
    logic            bad_index;
    logic            full;
    logic            is_load;
    logic            is_query;
    logic            wr_en;
    logic [AW-1:0]   rd_addr;
    logic            scan_issue;
    logic            hit_within;
    logic            hit_around;
    logic [IndexW-1:0] within_sat;
    logic [IndexW-1:0] around_sat;

    function automatic logic [IndexW-1:0] clamp_count(input logic [CW-1:0] cnt);
        logic [XW-1:0] wide;
        wide = XW'(cnt);
        clamp_count = (wide > XW'(CountLimit)) ? IndexW'(CountLimit) : wide[IndexW-1:0];
    endfunction

    assign q_ext     = XW'(i_query_index);
    assign count_ext = XW'(r_count);
    assign bad_index = (q_ext >= count_ext);
    assign full      = (r_count == CW'(MAX_RANGES));
    assign is_load   = (i_action == ActLoad);
    assign is_query  = (i_action == ActQuery);
    assign wr_en     = i_cmd.accept & is_load & ~full;

    assign scan_issue = i_cmd.scan & (r_scan != r_count);
    assign rd_addr    = i_cmd.accept ? q_ext[AW-1:0] : r_scan[AW-1:0];

    assign hit_within = (r_rd_left >= r_q_left) && (r_rd_right <= r_q_right);
    assign hit_around = (r_rd_left <= r_q_left) && (r_rd_right >= r_q_right);

    assign within_sat = clamp_count(r_within);
    assign around_sat = clamp_count(r_around);

    always_comb begin
        o_stat.need_scan = is_query & ~bad_index;
        o_stat.scan_done = ~r_pend & (r_scan == r_count);
        o_stat.out_free  = ~r_out_valid | o_out.ready;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_left_mem[r_count[AW-1:0]]  <= i_left_end;
            r_right_mem[r_count[AW-1:0]] <= i_right_end;
        end
        r_rd_left  <= r_left_mem[rd_addr];
        r_rd_right <= r_right_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pend  <= 1'b0;
            r_scan  <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_res_status   <= StatOk;
                r_res_assigned <= '0;
                r_within       <= '0;
                r_around       <= '0;
                r_q_idx        <= q_ext[AW-1:0];
                r_scan         <= '0;
                r_pend         <= 1'b0;
                if (is_load) begin
                    if (full) begin
                        r_res_status <= StatFull;
                    end else begin
                        r_res_assigned <= count_ext[IndexW-1:0];
                        r_count        <= r_count + CW'(1);
                    end
                end else if (is_query) begin
                    if (bad_index) begin
                        r_res_status <= StatBadIndex;
                    end
                end else if (i_action == ActClear) begin
                    r_count <= '0;
                end
            end
            if (i_cmd.qref) begin
                r_q_left  <= r_rd_left;
                r_q_right <= r_rd_right;
            end
            if (i_cmd.scan) begin
                r_pend     <= scan_issue;
                r_pend_idx <= r_scan[AW-1:0];
                if (scan_issue) begin
                    r_scan <= r_scan + CW'(1);
                end
                if (r_pend && (r_pend_idx != r_q_idx)) begin
                    if (hit_within) begin
                        r_within <= r_within + CW'(1);
                    end
                    if (hit_around) begin
                        r_around <= r_around + CW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_valid    <= 1'b1;
            r_out_status   <= r_res_status;
            r_out_assigned <= r_res_assigned;
            r_out_contains <= within_sat;
            r_out_inside   <= around_sat;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out_status;
    assign o_out.assigned_index = r_out_assigned;
    assign o_out.contains_count = r_out_contains;
    assign o_out.inside_count   = r_out_inside;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_count) <= XW'(MAX_RANGES))
        else $error("Fill count exceeds the store depth.");

    a_pend_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (XW'(r_pend_idx) < count_ext))
        else $error("Scan compares an entry beyond the fill count.");

    a_valid_from_publish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.publish))
        else $error("Result register filled without a publish command.");

endmodule
